>>> rtl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types, codes and defaults of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

   localparam int MAX_ARGS_DEF   = 16;
   localparam int MAX_LOCALS_DEF = 16;
   localparam int MAX_STACK_DEF  = 16;
   localparam int CFG_W          = 5;
   localparam int DATA_W         = 32;
   localparam int BLOCK_W        = 16;

   typedef enum logic [1:0] {
      KIND_START, KIND_ARG, KIND_EXEC, KIND_BAD
   } kind_type;

   typedef enum logic [2:0] {
      GRP_IMM, GRP_DUP, GRP_LS, GRP_BIN, GRP_COND, GRP_RET, GRP_JUMP, GRP_BAD
   } group_type;

   typedef enum logic [2:0] {
      ST_OK, ST_UNDERFLOW, ST_OVERFLOW, ST_INDEX, ST_UNKNOWN, ST_DIV_ZERO
   } status_type;

   typedef enum logic [1:0] {
      CSR_ARG_COUNT, CSR_LOCAL_COUNT, CSR_STACK_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {
      WSEL_OPND, WSEL_A2, WSEL_RES
   } wr_sel_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD_A, S_RD_B, S_CAP_B, S_EXEC, S_DIV, S_WRITE,
      S_TOP_RD, S_TOP_CAP, S_EMIT, S_RET_RD, S_RET_CAP
   } state_type;

   localparam logic [3:0] LS_LOAD_LOCAL  = 4'd0;
   localparam logic [3:0] LS_LOAD_ARG    = 4'd1;
   localparam logic [3:0] LS_STORE_LOCAL = 4'd2;
   localparam logic [3:0] LS_STORE_ARG   = 4'd3;

   localparam logic [3:0] ALU_ADD = 4'd0;
   localparam logic [3:0] ALU_SUB = 4'd1;
   localparam logic [3:0] ALU_MUL = 4'd2;
   localparam logic [3:0] ALU_DIV = 4'd3;
   localparam logic [3:0] ALU_MOD = 4'd4;
   localparam logic [3:0] ALU_AND = 4'd5;
   localparam logic [3:0] ALU_OR  = 4'd6;
   localparam logic [3:0] ALU_XOR = 4'd7;
   localparam logic [3:0] ALU_LSH = 4'd8;
   localparam logic [3:0] ALU_RSH = 4'd9;

   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_GT = 4'd1;
   localparam logic [3:0] COND_LT = 4'd2;
   localparam logic [3:0] COND_NE = 4'd3;
   localparam logic [3:0] COND_LE = 4'd4;
   localparam logic [3:0] COND_GE = 4'd5;

   typedef struct packed {
      logic       in_load;
      logic       rd_en;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cap_a2;
      logic       cap_a1;
      logic       cap_val;
      logic       alu_load;
      logic       div_start;
      logic [3:0] alu_op;
      logic       out_load;
      status_type status;
      logic       taken;
      logic       returning;
      logic       has_value;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic a2_zero;
      logic cond_true;
      logic div_busy;
      logic out_busy;
   } dp_status_type;

endpackage

>>> rtl/stack_machine_execute_unit_core.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core
// Execute unit of a stack machine: runs one function frame, one item each.
// ----------------------------------------------------------------------------
// req channel: one item per handshake (start frame, write argument, execute);
//   req_tuser carries the kind. rsp channel: result items, rsp_tlast on the
//   final result of an item. csr port: arg_count, local_count, stack_limit;
//   the user must write these only while the unit is idle; no check in the unit.
// one item is in work at a time; req_tready is high in the idle state, also
//   while the last result still waits in the output register.
// divide and modulo run in the serial divider, one quotient bit per cycle;
//   a return reads and emits the stacked values one by one.
// a stalled receiver holds the result register; the sequencer waits in its
//   emit step until the register is free.
// reset clears the stack depth, halt flag, counts (stack limit back to 16) and
//   the valid bits of the frame store, so unwritten slots read as zero.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_core #(
   parameter int MAX_ARGS   = smeu_pkg::MAX_ARGS_DEF,
   parameter int MAX_LOCALS = smeu_pkg::MAX_LOCALS_DEF,
   parameter int MAX_STACK  = smeu_pkg::MAX_STACK_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic [1:0]                 csr_index,
   input  logic [smeu_pkg::CFG_W-1:0] csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // group[2:0], sub_op[6:3], slot[10:7], operand[42:11], target_block[58:43]
   input  logic [63:0]                req_tdata,
   // kind[1:0]
   input  logic [1:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[2:0], branch_taken[3], branch_block[19:4], returning[20],
   // has_value[21], value[53:22]
   output logic [55:0]                rsp_tdata,
   output logic                       rsp_tlast
);
   import smeu_pkg::*;

   localparam int AW = $clog2(MAX_ARGS + MAX_LOCALS + MAX_STACK);

   cmd_type            cmd;
   dp_status_type      dp_status;
   logic [AW-1:0]      rd_addr, wr_addr;
   status_type         out_status;
   logic               out_taken, out_returning, out_has_value;
   logic [BLOCK_W-1:0] out_block;
   logic [DATA_W-1:0]  out_value;

   smeu_ctrl #(
      .MAX_ARGS(MAX_ARGS), .MAX_LOCALS(MAX_LOCALS), .MAX_STACK(MAX_STACK), .AW(AW)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_kind(req_tuser), .req_group(req_tdata[2:0]),
      .req_sub_op(req_tdata[6:3]), .req_slot(req_tdata[10:7]),
      .dp_status(dp_status), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr)
   );

   smeu_dp #(
      .MAX_ARGS(MAX_ARGS), .MAX_LOCALS(MAX_LOCALS), .MAX_STACK(MAX_STACK), .AW(AW)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .rd_addr(rd_addr), .wr_addr(wr_addr),
      .in_operand(req_tdata[42:11]), .in_target(req_tdata[58:43]),
      .dp_status(dp_status), .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid),
      .out_status(out_status), .out_taken(out_taken), .out_block(out_block),
      .out_returning(out_returning), .out_has_value(out_has_value),
      .out_value(out_value), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_value, out_has_value, out_returning,
                       out_block, out_taken, out_status};

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   a_error_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] != ST_OK)) |-> (!rsp_tdata[21] && !rsp_tdata[3]))
      else $error("error result carries a value or a branch");

   a_return_no_branch: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20]) |-> !rsp_tdata[3])
      else $error("return result flags a branch");
`endif

endmodule

>>> rtl/smeu_ctrl.sv
// ----------------------------------------------------------------------------
// smeu_ctrl
// Sequencer: decodes items, checks stack and index limits, steps the datapath.
// ----------------------------------------------------------------------------
module smeu_ctrl #(
   parameter int MAX_ARGS   = smeu_pkg::MAX_ARGS_DEF,
   parameter int MAX_LOCALS = smeu_pkg::MAX_LOCALS_DEF,
   parameter int MAX_STACK  = smeu_pkg::MAX_STACK_DEF,
   parameter int AW         = $clog2(MAX_ARGS + MAX_LOCALS + MAX_STACK)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [1:0]                  csr_index,
   input  logic [smeu_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_kind,
   input  logic [2:0]                  req_group,
   input  logic [3:0]                  req_sub_op,
   input  logic [3:0]                  req_slot,
   input  smeu_pkg::dp_status_type     dp_status,
   output smeu_pkg::cmd_type           cmd,
   output logic [AW-1:0]               rd_addr,
   output logic [AW-1:0]               wr_addr
);
   import smeu_pkg::*;

   localparam int DW         = $clog2(MAX_STACK + 1);
   localparam int STACK_BASE = MAX_ARGS + MAX_LOCALS;

   state_type        state_ff, state_in;
   kind_type         kind_ff, kind_in;
   group_type        group_ff, group_in;
   logic [3:0]       sub_ff, sub_in;
   logic [3:0]       slot_ff, slot_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic             halted_ff, halted_in;
   logic [CFG_W-1:0] arg_cnt_ff, loc_cnt_ff, lim_ff;
   logic [DW-1:0]    ret_n_ff, ret_n_in;
   logic [DW-1:0]    ret_idx_ff, ret_idx_in;
   status_type       status_ff, status_in;
   logic             taken_ff, taken_in;
   logic             returning_ff, returning_in;
   logic             hasv_ff, hasv_in;
   logic             last_ff, last_in;

   logic             full, bin_over, loc_ok, arg_ok, idx_ok, is_local, is_load;
   status_type       dec_status;
   logic [AW-1:0]    slot_addr, top_addr, second_addr, push_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         halted_ff    <= 1'b0;
         arg_cnt_ff   <= '0;
         loc_cnt_ff   <= '0;
         lim_ff       <= CFG_W'(16);
         kind_ff      <= KIND_START;
         group_ff     <= GRP_IMM;
         sub_ff       <= '0;
         slot_ff      <= '0;
         ret_n_ff     <= '0;
         ret_idx_ff   <= '0;
         status_ff    <= ST_OK;
         taken_ff     <= 1'b0;
         returning_ff <= 1'b0;
         hasv_ff      <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         halted_ff    <= halted_in;
         kind_ff      <= kind_in;
         group_ff     <= group_in;
         sub_ff       <= sub_in;
         slot_ff      <= slot_in;
         ret_n_ff     <= ret_n_in;
         ret_idx_ff   <= ret_idx_in;
         status_ff    <= status_in;
         taken_ff     <= taken_in;
         returning_ff <= returning_in;
         hasv_ff      <= hasv_in;
         last_ff      <= last_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_ARG_COUNT:   arg_cnt_ff <= csr_wdata;
               CSR_LOCAL_COUNT: loc_cnt_ff <= csr_wdata;
               CSR_STACK_LIMIT: lim_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      full = (32'(depth_ff) >= 32'(lim_ff)) || (32'(depth_ff) >= MAX_STACK);
      // result slot of a binary op lies beyond a lowered limit
      bin_over = (32'(depth_ff) >= 32'(lim_ff) + 2) || (32'(depth_ff) >= MAX_STACK + 2);
      loc_ok = ({1'b0, slot_ff} < loc_cnt_ff) && (32'(slot_ff) < MAX_LOCALS);
      arg_ok = ({1'b0, slot_ff} < arg_cnt_ff) && (32'(slot_ff) < MAX_ARGS);
      is_local = (sub_ff == LS_LOAD_LOCAL) || (sub_ff == LS_STORE_LOCAL);
      is_load  = (sub_ff == LS_LOAD_LOCAL) || (sub_ff == LS_LOAD_ARG);
      idx_ok = is_local ? loc_ok : arg_ok;
      slot_addr = is_local ? AW'(MAX_ARGS + 32'(slot_ff)) : AW'(slot_ff);
      top_addr    = AW'(STACK_BASE + 32'(depth_ff) - 1);
      second_addr = AW'(STACK_BASE + 32'(depth_ff) - 2);
      push_addr   = AW'(STACK_BASE + 32'(depth_ff));

      dec_status = ST_OK;
      unique case (group_ff)
         GRP_IMM:  if (full) dec_status = ST_OVERFLOW;
         GRP_DUP: begin
            if (depth_ff == '0) dec_status = ST_UNDERFLOW;
            else if (full) dec_status = ST_OVERFLOW;
         end
         GRP_LS: begin
            if (is_load) begin
               if (!idx_ok) dec_status = ST_INDEX;
               else if (full) dec_status = ST_OVERFLOW;
            end else if ((sub_ff == LS_STORE_LOCAL) || (sub_ff == LS_STORE_ARG)) begin
               if (depth_ff == '0) dec_status = ST_UNDERFLOW;
               else if (!idx_ok) dec_status = ST_INDEX;
            end else begin
               dec_status = ST_UNKNOWN;
            end
         end
         GRP_BIN: begin
            if (depth_ff < DW'(2)) dec_status = ST_UNDERFLOW;
            else if (sub_ff > ALU_RSH) dec_status = ST_UNKNOWN;
            else if (bin_over && (sub_ff != ALU_DIV) && (sub_ff != ALU_MOD))
               dec_status = ST_OVERFLOW;
         end
         GRP_COND: begin
            if (depth_ff < DW'(2)) dec_status = ST_UNDERFLOW;
            else if (sub_ff > COND_GE) dec_status = ST_UNKNOWN;
         end
         GRP_RET, GRP_JUMP: dec_status = ST_OK;
         GRP_BAD: dec_status = ST_UNKNOWN;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      group_in     = group_ff;
      sub_in       = sub_ff;
      slot_in      = slot_ff;
      depth_in     = depth_ff;
      halted_in    = halted_ff;
      ret_n_in     = ret_n_ff;
      ret_idx_in   = ret_idx_ff;
      status_in    = status_ff;
      taken_in     = taken_ff;
      returning_in = returning_ff;
      hasv_in      = hasv_ff;
      last_in      = last_ff;
      req_tready   = 1'b0;
      rd_addr      = top_addr;
      wr_addr      = push_addr;
      cmd           = '0;
      cmd.wr_sel    = WSEL_OPND;
      cmd.status    = status_ff;
      cmd.taken     = taken_ff;
      cmd.returning = returning_ff;
      cmd.has_value = hasv_ff;
      cmd.last      = last_ff;
      cmd.alu_op    = sub_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.in_load = 1'b1;
               kind_in  = kind_type'(req_kind);
               group_in = group_type'(req_group);
               sub_in   = req_sub_op;
               slot_in  = req_slot;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in    = ST_OK;
            taken_in     = 1'b0;
            returning_in = 1'b0;
            hasv_in      = 1'b0;
            last_in      = 1'b1;
            state_in     = S_EMIT;
            unique case (kind_ff)
               KIND_START: begin
                  depth_in  = '0;
                  halted_in = 1'b0;
               end
               KIND_ARG: begin
                  wr_addr = AW'(slot_ff);
                  if (arg_ok) cmd.wr_en = 1'b1;
                  else status_in = ST_INDEX;
               end
               KIND_BAD: status_in = ST_UNKNOWN;
               KIND_EXEC: begin
                  if (halted_ff) begin
                     state_in = S_IDLE;
                  end else if (dec_status != ST_OK) begin
                     status_in = dec_status;
                     halted_in = 1'b1;
                  end else begin
                     unique case (group_ff)
                        GRP_IMM: state_in = S_WRITE;
                        GRP_DUP, GRP_LS, GRP_BIN, GRP_COND: state_in = S_RD_A;
                        GRP_RET: begin
                           ret_n_in     = depth_ff;
                           ret_idx_in   = '0;
                           depth_in     = '0;
                           halted_in    = 1'b1;
                           returning_in = 1'b1;
                           if (depth_ff != '0) state_in = S_RET_RD;
                        end
                        GRP_JUMP: begin
                           taken_in = 1'b1;
                           state_in = S_TOP_RD;
                        end
                        GRP_BAD: state_in = S_IDLE;
                     endcase
                  end
               end
            endcase
         end
         S_RD_A: begin
            cmd.rd_en = 1'b1;
            rd_addr   = ((group_ff == GRP_LS) && is_load) ? slot_addr : top_addr;
            state_in  = S_RD_B;
         end
         S_RD_B: begin
            cmd.cap_a2 = 1'b1;
            if ((group_ff == GRP_BIN) || (group_ff == GRP_COND)) begin
               cmd.rd_en = 1'b1;
               rd_addr   = second_addr;
               state_in  = S_CAP_B;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_CAP_B: begin
            cmd.cap_a1 = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            if (group_ff == GRP_COND) begin
               taken_in = dp_status.cond_true;
               depth_in = DW'(depth_ff - DW'(2));
               state_in = S_TOP_RD;
            end else if ((sub_ff == ALU_DIV) || (sub_ff == ALU_MOD)) begin
               if (dp_status.a2_zero) begin
                  status_in = ST_DIV_ZERO;
                  halted_in = 1'b1;
                  state_in  = S_EMIT;
               end else if (bin_over) begin
                  status_in = ST_OVERFLOW;
                  halted_in = 1'b1;
                  state_in  = S_EMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               cmd.alu_load = 1'b1;
               state_in     = S_WRITE;
            end
         end
         S_DIV: if (!dp_status.div_busy) state_in = S_WRITE;
         S_WRITE: begin
            state_in = S_TOP_RD;
            unique case (group_ff)
               GRP_IMM: begin
                  cmd.wr_en = 1'b1;
                  depth_in  = DW'(depth_ff + DW'(1));
               end
               GRP_DUP: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WSEL_A2;
                  depth_in   = DW'(depth_ff + DW'(1));
               end
               GRP_LS: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WSEL_A2;
                  if (is_load) begin
                     depth_in = DW'(depth_ff + DW'(1));
                  end else begin
                     wr_addr  = slot_addr;
                     depth_in = DW'(depth_ff - DW'(1));
                  end
               end
               GRP_BIN: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WSEL_RES;
                  wr_addr    = second_addr;
                  depth_in   = DW'(depth_ff - DW'(1));
               end
               default: ;
            endcase
         end
         S_TOP_RD: begin
            if (depth_ff == '0) begin
               hasv_in  = 1'b0;
               state_in = S_EMIT;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_TOP_CAP;
            end
         end
         S_TOP_CAP: begin
            cmd.cap_val = 1'b1;
            hasv_in     = 1'b1;
            state_in    = S_EMIT;
         end
         S_RET_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = AW'(STACK_BASE + 32'(ret_idx_ff));
            state_in  = S_RET_CAP;
         end
         S_RET_CAP: begin
            cmd.cap_val = 1'b1;
            hasv_in     = 1'b1;
            last_in     = (DW'(ret_idx_ff + DW'(1)) == ret_n_ff);
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (!dp_status.out_busy) begin
               cmd.out_load = 1'b1;
               if (returning_ff && !last_ff) begin
                  ret_idx_in = DW'(ret_idx_ff + DW'(1));
                  state_in   = S_RET_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> rtl/smeu_dp.sv
// ----------------------------------------------------------------------------
// smeu_dp
// Datapath: frame store, operand registers, alu, serial divider, result register.
// ----------------------------------------------------------------------------
module smeu_dp #(
   parameter int MAX_ARGS   = smeu_pkg::MAX_ARGS_DEF,
   parameter int MAX_LOCALS = smeu_pkg::MAX_LOCALS_DEF,
   parameter int MAX_STACK  = smeu_pkg::MAX_STACK_DEF,
   parameter int AW         = $clog2(MAX_ARGS + MAX_LOCALS + MAX_STACK)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smeu_pkg::cmd_type             cmd,
   input  logic [AW-1:0]                 rd_addr,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [smeu_pkg::DATA_W-1:0]   in_operand,
   input  logic [smeu_pkg::BLOCK_W-1:0]  in_target,
   output smeu_pkg::dp_status_type       dp_status,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output smeu_pkg::status_type          out_status,
   output logic                          out_taken,
   output logic [smeu_pkg::BLOCK_W-1:0]  out_block,
   output logic                          out_returning,
   output logic                          out_has_value,
   output logic [smeu_pkg::DATA_W-1:0]   out_value,
   output logic                          out_last
);
   import smeu_pkg::*;

   localparam int DEPTH = MAX_ARGS + MAX_LOCALS + MAX_STACK;

   logic [DATA_W-1:0]  mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [DATA_W-1:0]  rdata_ff, opnd_ff, a1_ff, a2_ff, res_ff, val_ff;
   logic [BLOCK_W-1:0] tgt_ff;
   logic [DATA_W-1:0]  rem_ff, quo_ff;
   logic [5:0]         cnt_ff;
   logic               div_busy_ff, out_valid_ff;
   logic [DATA_W-1:0]  wr_data, alu_res, rem_nx, quo_nx;
   logic [DATA_W:0]    rem_sh;
   logic               ge, cond_true;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rdata_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WSEL_A2:  wr_data = a2_ff;
         WSEL_RES: wr_data = res_ff;
         default:  wr_data = opnd_ff;
      endcase

      unique case (cmd.alu_op)
         ALU_ADD: alu_res = a1_ff + a2_ff;
         ALU_SUB: alu_res = a1_ff - a2_ff;
         ALU_MUL: alu_res = DATA_W'(a1_ff * a2_ff);
         ALU_AND: alu_res = a1_ff & a2_ff;
         ALU_OR:  alu_res = a1_ff | a2_ff;
         ALU_XOR: alu_res = a1_ff ^ a2_ff;
         ALU_LSH: alu_res = (a2_ff >= 32'd32) ? '0 : a1_ff << a2_ff[4:0];
         ALU_RSH: alu_res = (a2_ff >= 32'd32) ? '0 : a1_ff >> a2_ff[4:0];
         default: alu_res = '0;
      endcase

      unique case (cmd.alu_op)
         COND_EQ: cond_true = (a1_ff == a2_ff);
         COND_GT: cond_true = (a1_ff > a2_ff);
         COND_LT: cond_true = (a1_ff < a2_ff);
         COND_NE: cond_true = (a1_ff != a2_ff);
         COND_LE: cond_true = (a1_ff <= a2_ff);
         COND_GE: cond_true = (a1_ff >= a2_ff);
         default: cond_true = 1'b0;
      endcase

      rem_sh = {rem_ff, quo_ff[DATA_W-1]};
      ge     = (rem_sh >= {1'b0, a2_ff});
      rem_nx = ge ? DATA_W'(rem_sh - {1'b0, a2_ff}) : rem_sh[DATA_W-1:0];
      quo_nx = {quo_ff[DATA_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
            cnt_ff      <= 6'd32;
         end else if (div_busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) div_busy_ff <= 1'b0;
         end
         if (cmd.out_load) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.in_load) begin
         opnd_ff <= in_operand;
         tgt_ff  <= in_target;
      end
      if (cmd.cap_a2) a2_ff <= rdata_ff;
      if (cmd.cap_a1) a1_ff <= rdata_ff;
      if (cmd.cap_val) val_ff <= rdata_ff;
      if (cmd.alu_load) res_ff <= alu_res;
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= a1_ff;
      end else if (div_busy_ff) begin
         rem_ff <= rem_nx;
         quo_ff <= quo_nx;
         if (cnt_ff == 6'd1) res_ff <= (cmd.alu_op == ALU_MOD) ? rem_nx : quo_nx;
      end
      if (cmd.out_load) begin
         out_status    <= cmd.status;
         out_taken     <= cmd.taken;
         out_block     <= cmd.taken ? tgt_ff : '0;
         out_returning <= cmd.returning;
         out_has_value <= cmd.has_value;
         out_value     <= cmd.has_value ? val_ff : '0;
         out_last      <= cmd.last;
      end
   end

   assign rsp_tvalid          = out_valid_ff;
   assign dp_status.a2_zero   = (a2_ff == '0);
   assign dp_status.cond_true = cond_true;
   assign dp_status.div_busy  = div_busy_ff;
   assign dp_status.out_busy  = out_valid_ff && !rsp_tready;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stack machine execute unit: a directed table
// of frame starts, argument writes and instructions, then random programs,
// all checked item by item against a behavioral predictor of the frame.
// ----------------------------------------------------------------------------
module tb;
   import smeu_pkg::*;

   localparam int NA = 16;
   localparam int NL = 16;
   localparam int NS = 16;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [2:0]  status;
      logic        taken;
      logic [15:0] block;
      logic        ret;
      logic        hasv;
      logic [31:0] value;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  grp;
      logic [3:0]  sub;
      logic [3:0]  slot;
      logic [31:0] opnd;
      logic [15:0] tblk;
   } instr_type;

   typedef struct {
      instr_type  ins;
      logic       has_exp;
      logic [2:0] exp_status;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wen = 0;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;

   stack_machine_execute_unit_core u_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] frame_mem [NA+NL+NS];
   int unsigned depth;
   logic        halt_flag;
   int unsigned n_args, n_locals, s_limit;
   result_type  pending_results [$];

   int errors = 0;
   int cycles = 0;
   int n_results = 0;
   int n_items = 0;
   int send_idle = 7;
   int recv_idle = 63;
   logic hold_off = 0;

   function automatic int unsigned clampv(int unsigned v, int unsigned hi);
      return v > hi ? hi : v;
   endfunction

   function automatic result_type mk(logic [2:0] st, logic tk, logic [15:0] bl, logic rt,
                                     logic hv, logic [31:0] v, logic ls);
      result_type r;
      r.status = st; r.taken = tk; r.block = bl; r.ret = rt;
      r.hasv = hv; r.value = v; r.last = ls;
      return r;
   endfunction

   function automatic int sidx(int unsigned i);
      return NA + NL + (i % NS);
   endfunction

   task automatic predict_frame(instr_type it);
      int unsigned na, nl, lim, d, cnt;
      logic [31:0] a1, a2, r;
      logic [2:0] st;
      logic tk;
      logic [15:0] bl;
      na = clampv(n_args, NA); nl = clampv(n_locals, NL); lim = clampv(s_limit, NS);
      d = depth; st = ST_OK; tk = 0; bl = 0; r = 0;
      case (it.kind)
         KIND_START: begin
            depth = 0; halt_flag = 0;
            pending_results.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
            return;
         end
         KIND_ARG: begin
            if (it.slot < na) frame_mem[it.slot] = it.opnd; else st = ST_INDEX;
            pending_results.push_back(mk(st, 0, 0, 0, 0, 0, 1));
            return;
         end
         KIND_BAD: begin
            pending_results.push_back(mk(ST_UNKNOWN, 0, 0, 0, 0, 0, 1));
            return;
         end
         default: ;
      endcase
      if (halt_flag) return;
      case (it.grp)
         GRP_IMM: begin
            if (d >= lim) st = ST_OVERFLOW;
            else begin frame_mem[sidx(d)] = it.opnd; d++; end
         end
         GRP_DUP: begin
            if (d < 1) st = ST_UNDERFLOW;
            else if (d >= lim) st = ST_OVERFLOW;
            else begin frame_mem[sidx(d)] = frame_mem[sidx(d-1)]; d++; end
         end
         GRP_LS: begin
            if (it.sub == LS_LOAD_LOCAL || it.sub == LS_LOAD_ARG) begin
               cnt = it.sub == LS_LOAD_LOCAL ? nl : na;
               if (it.slot >= cnt) st = ST_INDEX;
               else if (d >= lim) st = ST_OVERFLOW;
               else begin
                  frame_mem[sidx(d)] = it.sub == LS_LOAD_LOCAL ?
                     frame_mem[NA + it.slot] : frame_mem[it.slot];
                  d++;
               end
            end else if (it.sub == LS_STORE_LOCAL || it.sub == LS_STORE_ARG) begin
               cnt = it.sub == LS_STORE_LOCAL ? nl : na;
               if (d < 1) st = ST_UNDERFLOW;
               else if (it.slot >= cnt) st = ST_INDEX;
               else begin
                  d--;
                  if (it.sub == LS_STORE_LOCAL) frame_mem[NA + it.slot] = frame_mem[sidx(d)];
                  else frame_mem[it.slot] = frame_mem[sidx(d)];
               end
            end else st = ST_UNKNOWN;
         end
         GRP_BIN: begin
            if (d < 2) st = ST_UNDERFLOW;
            else begin
               a2 = frame_mem[sidx(d-1)]; a1 = frame_mem[sidx(d-2)];
               case (it.sub)
                  ALU_ADD: r = a1 + a2;
                  ALU_SUB: r = a1 - a2;
                  ALU_MUL: r = a1 * a2;
                  ALU_DIV: if (a2 == 0) st = ST_DIV_ZERO; else r = a1 / a2;
                  ALU_MOD: if (a2 == 0) st = ST_DIV_ZERO; else r = a1 % a2;
                  ALU_AND: r = a1 & a2;
                  ALU_OR:  r = a1 | a2;
                  ALU_XOR: r = a1 ^ a2;
                  ALU_LSH: r = a2 >= 32 ? 0 : a1 << a2;
                  ALU_RSH: r = a2 >= 32 ? 0 : a1 >> a2;
                  default: st = ST_UNKNOWN;
               endcase
               if (st == ST_OK) begin
                  if (d - 2 >= lim) st = ST_OVERFLOW;
                  else begin frame_mem[sidx(d-2)] = r; d--; end
               end
            end
         end
         GRP_COND: begin
            if (d < 2) st = ST_UNDERFLOW;
            else begin
               a2 = frame_mem[sidx(d-1)]; a1 = frame_mem[sidx(d-2)];
               case (it.sub)
                  COND_EQ: tk = a1 == a2;
                  COND_GT: tk = a1 > a2;
                  COND_LT: tk = a1 < a2;
                  COND_NE: tk = a1 != a2;
                  COND_LE: tk = a1 <= a2;
                  COND_GE: tk = a1 >= a2;
                  default: st = ST_UNKNOWN;
               endcase
               if (st == ST_OK) begin
                  d -= 2;
                  if (tk) bl = it.tblk;
               end else tk = 0;
            end
         end
         GRP_RET: begin
            if (d == 0) pending_results.push_back(mk(ST_OK, 0, 0, 1, 0, 0, 1));
            else
               for (int unsigned i = 0; i < d && i < NS; i++)
                  pending_results.push_back(mk(ST_OK, 0, 0, 1, 1, frame_mem[sidx(i)],
                                               i + 1 == d));
            depth = 0; halt_flag = 1;
            return;
         end
         GRP_JUMP: begin tk = 1; bl = it.tblk; end
         default: st = ST_UNKNOWN;
      endcase
      if (st != ST_OK) begin
         halt_flag = 1;
         pending_results.push_back(mk(st, 0, 0, 0, 0, 0, 1));
         return;
      end
      depth = d;
      if (d > 0) pending_results.push_back(mk(ST_OK, tk, bl, 0, 1, frame_mem[sidx(d-1)], 1));
      else pending_results.push_back(mk(ST_OK, tk, bl, 0, 0, 0, 1));
   endtask

   // result checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[2:0], rsp_tdata[3], rsp_tdata[19:4], rsp_tdata[20],
                   rsp_tdata[21], rsp_tdata[53:22], rsp_tlast};
            n_results++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
   end

   task automatic send_item(instr_type it);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= it.kind;
      req_tdata <= {5'b0, it.tblk, it.opnd, it.slot, it.sub, it.grp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame(it);
      n_items++;
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned v);
      csr_wen <= 1; csr_index <= idx; csr_wdata <= v[4:0];
      @(posedge clock);
      csr_wen <= 0;
      case (idx)
         CSR_ARG_COUNT:   n_args = v[4:0];
         CSR_LOCAL_COUNT: n_locals = v[4:0];
         default:         s_limit = v[4:0];
      endcase
      @(posedge clock);
   endtask

   function automatic instr_type mi(kind_type k, group_type g, int unsigned s,
                                    int unsigned sl, logic [31:0] o, logic [15:0] t);
      instr_type it;
      it.kind = k; it.grp = g; it.sub = s[3:0]; it.slot = sl[3:0];
      it.opnd = o; it.tblk = t;
      return it;
   endfunction

   function automatic instr_type rand_instr();
      instr_type it;
      int p;
      p = $urandom_range(99);
      it = mi(KIND_EXEC, GRP_IMM, 0, $urandom_range(15), $urandom,
              16'($urandom_range(65535)));
      if (p < 4) it.kind = KIND_START;
      else if (p < 10) it.kind = KIND_ARG;
      else if (p < 11) it.kind = KIND_BAD;
      else if (p < 40) begin
         it.grp = GRP_IMM;
         if ($urandom_range(3) == 0) it.opnd = $urandom_range(40);
      end else if (p < 46) it.grp = GRP_DUP;
      else if (p < 60) begin it.grp = GRP_LS; it.sub = 4'($urandom_range(3)); end
      else if (p < 78) begin
         it.grp = GRP_BIN; it.sub = 4'($urandom_range(9));
         if (it.sub == ALU_DIV || it.sub == ALU_MOD) it.sub = 4'($urandom_range(9));
      end else if (p < 88) begin it.grp = GRP_COND; it.sub = 4'($urandom_range(5)); end
      else if (p < 92) it.grp = GRP_JUMP;
      else if (p < 95) it.grp = GRP_RET;
      else begin
         it.grp = group_type'($urandom_range(7));
         it.sub = 4'($urandom_range(15));
      end
      return it;
   endfunction

   row_type directed [$];

   task automatic add_row(instr_type it, logic he = 0, logic [2:0] es = ST_OK);
      row_type r;
      r.ins = it; r.has_exp = he; r.exp_status = es;
      directed.push_back(r);
   endtask

   initial begin
      logic [31:0] ones;
      ones = 32'hFFFF_FFFF;
      foreach (frame_mem[i]) frame_mem[i] = 0;
      depth = 0; halt_flag = 0; n_args = 0; n_locals = 0; s_limit = 16;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add_row(mi(KIND_ARG, GRP_IMM, 0, 0, ones, 0), 1, ST_INDEX);
      add_row(mi(KIND_BAD, GRP_BAD, 15, 15, ones, 16'hFFFF), 1, ST_UNKNOWN);
      add_row(mi(KIND_EXEC, GRP_RET, 0, 0, 0, 0));
      add_row(mi(KIND_START, GRP_IMM, 0, 0, 0, 0), 1, ST_OK);
      add_row(mi(KIND_EXEC, GRP_IMM, 0, 0, ones, 0));
      add_row(mi(KIND_EXEC, GRP_IMM, 0, 0, 0, 0));
      add_row(mi(KIND_EXEC, GRP_BIN, ALU_DIV, 0, 0, 0), 1, ST_DIV_ZERO);
      add_row(mi(KIND_START, GRP_IMM, 0, 0, 0, 0), 1, ST_OK);
      add_row(mi(KIND_EXEC, GRP_DUP, 0, 0, 0, 0), 1, ST_UNDERFLOW);
      add_row(mi(KIND_START, GRP_IMM, 0, 0, 0, 0), 1, ST_OK);
      add_row(mi(KIND_EXEC, GRP_IMM, 0, 0, 32'h8000_0001, 0));
      add_row(mi(KIND_EXEC, GRP_IMM, 0, 0, 32, 0));
      add_row(mi(KIND_EXEC, GRP_BIN, ALU_LSH, 0, 0, 0));
      add_row(mi(KIND_EXEC, GRP_IMM, 0, 0, 7, 0));
      add_row(mi(KIND_EXEC, GRP_COND, COND_LT, 0, 0, 16'hFFFF));
      add_row(mi(KIND_EXEC, GRP_JUMP, 0, 0, 0, 16'hFFFF));
      add_row(mi(KIND_EXEC, GRP_LS, LS_LOAD_ARG, 15, 0, 0), 1, ST_INDEX);
      add_row(mi(KIND_START, GRP_IMM, 0, 0, 0, 0), 1, ST_OK);
      add_row(mi(KIND_EXEC, GRP_LS, 4, 0, 0, 0), 1, ST_UNKNOWN);
      add_row(mi(KIND_START, GRP_IMM, 0, 0, 0, 0), 1, ST_OK);
      add_row(mi(KIND_EXEC, GRP_BAD, 0, 0, 0, 0), 1, ST_UNKNOWN);
      add_row(mi(KIND_START, GRP_IMM, 0, 0, 0, 0), 1, ST_OK);
      add_row(mi(KIND_EXEC, GRP_IMM, 0, 0, 1, 0));
      add_row(mi(KIND_EXEC, GRP_IMM, 0, 0, 2, 0));
      add_row(mi(KIND_EXEC, GRP_RET, 0, 0, 0, 0));

      foreach (directed[i]) begin
         send_item(directed[i].ins);
         if (directed[i].has_exp && pending_results.size() != 0 &&
             pending_results[$].status !== directed[i].exp_status) begin
            $display("%0t: table row %0d expected status %0d, predicted %0d", $time, i,
                     directed[i].exp_status, pending_results[$].status);
            errors++;
         end
      end
      drain_results();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin send_idle = 63; recv_idle = 7; end
         if (ph == 4) begin send_idle = 0; recv_idle = 0; end
         case (ph)
            0: begin write_csr(CSR_ARG_COUNT, 16); write_csr(CSR_LOCAL_COUNT, 16);
                     write_csr(CSR_STACK_LIMIT, 16); end
            1: begin write_csr(CSR_ARG_COUNT, 0); write_csr(CSR_LOCAL_COUNT, 31);
                     write_csr(CSR_STACK_LIMIT, 1); end
            2: begin write_csr(CSR_ARG_COUNT, 31); write_csr(CSR_LOCAL_COUNT, 0);
                     write_csr(CSR_STACK_LIMIT, 31); end
            3: begin write_csr(CSR_ARG_COUNT, 5); write_csr(CSR_LOCAL_COUNT, 9);
                     write_csr(CSR_STACK_LIMIT, 0); end
            default: begin write_csr(CSR_ARG_COUNT, $urandom_range(31));
                     write_csr(CSR_LOCAL_COUNT, $urandom_range(31));
                     write_csr(CSR_STACK_LIMIT, $urandom_range(1, 16)); end
         endcase
         send_item(mi(KIND_START, GRP_IMM, 0, 0, 0, 0));
         if (ph == 4) fork
            begin
               hold_off = 1;
               repeat (300) @(posedge clock);
               hold_off = 0;
            end
         join_none
         for (int k = 0; k < 70; k++) begin
            if (halt_flag && $urandom_range(3) != 0)
               send_item(mi(KIND_START, GRP_IMM, 0, 0, 0, 0));
            send_item(rand_instr());
         end
         drain_results();
      end

      $display("ran %0d items, checked %0d results over six register settings",
               n_items, n_results);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
